[hw/rtl/poi_pkg.sv]
// shared widths, constants, control structs and the arctangent table
// for the planar odometry integrator; no dependencies
package poi_pkg;

	// field widths
	localparam int VEL_W   = 24;
	localparam int DT_W    = 20;
	localparam int POS_W   = 32;
	localparam int ANG_W   = 32;
	localparam int QUAT_W  = 16;

	// defaults for the top-level parameters
	localparam int CORDIC_STEPS_DEF = 16;
	localparam int POS_FRAC_DEF     = 16;

	// cordic datapath: x/y in q2.30 with headroom, z as signed binary angle
	localparam int CS_W       = 34;
	localparam int CZ_W       = 33;
	localparam int ATAN_IDX_W = 5;
	localparam int CORDIC_GAIN = 652032874;

	// serial multiply-accumulate
	localparam int ACC_W     = 76;
	localparam int MB_W      = 31;
	localparam int MAC_CNT_W = 5;

	// serial divider
	localparam int DVD_W     = 58;
	localparam int DQ_W      = 38;
	localparam int DIV_CNT_W = 6;

	// world velocity, q.26 after dropping 20 product bits
	localparam int WX_W       = 37;
	localparam int PROD_SHIFT = 20;

	// 2^31/pi in q.16, split point of the heading product
	localparam logic [MB_W-1:0] ANGLE_SCALE = MB_W'(683565276);
	localparam int ANGLE_FRAC        = 16;
	localparam int MICROS_PER_SECOND = 1000000;
	localparam int HEAD_QB           = 38;

	// item kinds
	localparam logic KIND_VELOCITY = 1'b0;
	localparam logic KIND_TICK     = 1'b1;

	typedef struct packed {
		logic                 start;
		logic                 clear;
		logic                 neg;
		logic [MAC_CNT_W-1:0] nbits;
	} mac_ctl_t;

	typedef struct packed {
		logic                 start;
		logic [DIV_CNT_W-1:0] nbits;
	} div_ctl_t;

	// arctangent of 2^-i in binary-angle units
	function automatic logic [ANG_W-1:0] cordic_atan(input logic [ATAN_IDX_W-1:0] idx);
		logic [ANG_W-1:0] r;
		unique case (idx)
			5'd0:  r = 32'h20000000;
			5'd1:  r = 32'h12E4051E;
			5'd2:  r = 32'h09FB385B;
			5'd3:  r = 32'h051111D4;
			5'd4:  r = 32'h028B0D43;
			5'd5:  r = 32'h0145D7E1;
			5'd6:  r = 32'h00A2F61E;
			5'd7:  r = 32'h00517C55;
			5'd8:  r = 32'h0028BE53;
			5'd9:  r = 32'h00145F2F;
			5'd10: r = 32'h000A2F98;
			5'd11: r = 32'h000517CC;
			5'd12: r = 32'h00028BE6;
			5'd13: r = 32'h000145F3;
			5'd14: r = 32'h0000A2F9;
			5'd15: r = 32'h0000517C;
			5'd16: r = 32'h000028BE;
			5'd17: r = 32'h0000145F;
			5'd18: r = 32'h00000A2F;
			5'd19: r = 32'h00000517;
			5'd20: r = 32'h0000028B;
			5'd21: r = 32'h00000145;
			5'd22: r = 32'h000000A2;
			5'd23: r = 32'h00000051;
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

[hw/rtl/poi_mac.sv]
// bit-serial signed multiply-accumulate, one multiplier bit per cycle
// depends on poi_pkg
module poi_mac (
	input  logic                                clk,
	input  logic                                arst_n,
	input  poi_pkg::mac_ctl_t                   ctl,
	input  logic signed [poi_pkg::ACC_W-1:0]    mcand,
	input  logic        [poi_pkg::MB_W-1:0]     mplier,
	output logic signed [poi_pkg::ACC_W-1:0]    acc,
	output logic                                done
);
	import poi_pkg::*;

	logic signed [ACC_W-1:0] acc_q;
	logic signed [ACC_W-1:0] mcand_q;
	logic [MB_W-1:0]         mplier_q;
	logic [MAC_CNT_W-1:0]    cnt_q;
	logic                    busy_q;
	logic                    neg_q;
	logic                    done_q;
	logic                    last;
	logic                    sub;

	// top multiplier bit carries negative weight
	assign last = (cnt_q == MAC_CNT_W'(1));
	assign sub  = last ^ neg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			neg_q  <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= busy_q && last && !ctl.start;
			if (ctl.start) begin
				busy_q <= 1'b1;
				cnt_q  <= ctl.nbits;
				neg_q  <= ctl.neg;
			end else if (busy_q) begin
				cnt_q <= cnt_q - MAC_CNT_W'(1);
				if (last) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			mcand_q  <= mcand;
			mplier_q <= mplier;
			if (ctl.clear) begin
				acc_q <= '0;
			end
		end else if (busy_q) begin
			mcand_q  <= mcand_q <<< 1;
			mplier_q <= mplier_q >> 1;
			if (mplier_q[0]) begin
				acc_q <= sub ? acc_q - mcand_q : acc_q + mcand_q;
			end
		end
	end

	assign acc  = acc_q;
	assign done = done_q;

endmodule

[hw/rtl/poi_div.sv]
// restoring divider, one quotient bit per cycle, divisor given pre-shifted
// depends on poi_pkg
module poi_div (
	input  logic                         clk,
	input  logic                         arst_n,
	input  poi_pkg::div_ctl_t            ctl,
	input  logic [poi_pkg::DVD_W-1:0]    dividend,
	input  logic [poi_pkg::DVD_W-1:0]    divisor,
	output logic [poi_pkg::DQ_W-1:0]     quotient,
	output logic                         done
);
	import poi_pkg::*;

	logic [DVD_W-1:0]     rem_q;
	logic [DVD_W-1:0]     dsr_q;
	logic [DQ_W-1:0]      quo_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 busy_q;
	logic                 done_q;
	logic [DVD_W:0]       diff;
	logic                 fits;

	assign diff = {1'b0, rem_q} - {1'b0, dsr_q};
	assign fits = !diff[DVD_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= busy_q && !ctl.start && (cnt_q == DIV_CNT_W'(1));
			if (ctl.start) begin
				busy_q <= 1'b1;
				cnt_q  <= ctl.nbits;
			end else if (busy_q) begin
				cnt_q <= cnt_q - DIV_CNT_W'(1);
				if (cnt_q == DIV_CNT_W'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			rem_q <= dividend;
			dsr_q <= divisor;
			quo_q <= '0;
		end else if (busy_q) begin
			if (fits) begin
				rem_q <= diff[DVD_W-1:0];
			end
			quo_q <= {quo_q[DQ_W-2:0], fits};
			dsr_q <= dsr_q >> 1;
		end
	end

	assign quotient = quo_q;
	assign done     = done_q;

endmodule

[hw/rtl/planar_odometry_integrator.sv]
// top level of the planar odometry integrator: sequencer, cordic, pose state
// depends on poi_pkg, poi_mac, poi_div
//
// Dead-reckoning pose integrator for a holonomic base. A velocity beat
// (kind 0) latches forward, lateral and turn rates and gives no
// result. A tick beat (kind 1) rotates the latched body velocity by the old
// heading, scales it by elapsed_us and adds it to the saturating position,
// advances the wrapping heading by rate times time and then delivers one
// pose beat: position, heading, yaw quaternion and the latched velocities.
// The pose beat's timing comes from the iterative cordic (one rotation per
// cycle, run twice) and from the bit-serial multiply-accumulate pair and
// restoring divider, which produce one product or quotient bit per cycle.
// The next command beat is taken as soon as the tick has finished, while
// the pose beat may still wait in the output register; a tick finishes
// only once the previous pose beat has left that register.
module planar_odometry_integrator #(
	parameter int CORDIC_STEPS           = poi_pkg::CORDIC_STEPS_DEF,
	parameter int POSITION_FRACTION_BITS = poi_pkg::POS_FRAC_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// command channel
	input  logic                                 cmd_valid,
	output logic                                 cmd_stall,
	input  logic                                 kind,
	input  logic signed [poi_pkg::VEL_W-1:0]     forward_velocity,
	input  logic signed [poi_pkg::VEL_W-1:0]     lateral_velocity,
	input  logic signed [poi_pkg::VEL_W-1:0]     turn_rate,
	input  logic        [poi_pkg::DT_W-1:0]      elapsed_us,
	// pose channel
	output logic                                 pose_valid,
	input  logic                                 pose_stall,
	output logic signed [poi_pkg::POS_W-1:0]     pos_x,
	output logic signed [poi_pkg::POS_W-1:0]     pos_y,
	output logic        [poi_pkg::ANG_W-1:0]     heading,
	output logic signed [poi_pkg::QUAT_W-1:0]    quat_z,
	output logic signed [poi_pkg::QUAT_W-1:0]    quat_w,
	output logic signed [poi_pkg::VEL_W-1:0]     vel_x_echo,
	output logic signed [poi_pkg::VEL_W-1:0]     vel_y_echo,
	output logic signed [poi_pkg::VEL_W-1:0]     rate_echo
);
	import poi_pkg::*;

	// position divide: den = 1e6 * 2^(26 - frac), quotient fits frac+10 bits
	localparam int DEN_SHIFT = 26 - POSITION_FRACTION_BITS;
	localparam int QB_POS    = POSITION_FRACTION_BITS + 10;
	localparam logic [DVD_W-1:0] POS_HALF =
		DVD_W'(MICROS_PER_SECOND) << (DEN_SHIFT - 1);
	localparam logic [DVD_W-1:0] POS_DSR =
		DVD_W'(MICROS_PER_SECOND) << (DEN_SHIFT + QB_POS - 1);
	localparam logic [DVD_W-1:0] HEAD_HALF = DVD_W'(MICROS_PER_SECOND / 2);
	localparam logic [DVD_W-1:0] HEAD_DSR  =
		DVD_W'(MICROS_PER_SECOND) << (HEAD_QB - 1);

	localparam int STEP_W = $clog2(CORDIC_STEPS);
	localparam int SUM_W  = DQ_W + 2;
	localparam int QS_W   = CS_W + 1;
	localparam int QH_W   = ACC_W - ANGLE_FRAC;
	localparam logic [ANG_W-1:0] QUARTER_TURN = ANG_W'(32'h4000_0000);
	localparam logic [ANG_W-1:0] HALF_TURN    = ANG_W'(32'h8000_0000);

	typedef enum logic [3:0] {
		S_IDLE, S_COR1, S_MUL_A, S_MUL_B, S_MUL_C, S_DIV_P,
		S_MUL_T, S_MUL_K, S_DIV_H, S_COR2, S_EMIT
	} state_t;

	state_t state_q;

	// architectural state
	logic signed [VEL_W-1:0] cmd_fwd_q, cmd_lat_q, cmd_turn_q;
	logic signed [POS_W-1:0] world_x_q, world_y_q;
	logic [ANG_W-1:0]        yaw_q;
	logic [DT_W-1:0]         dt_q;

	// pose output register
	logic                     pose_valid_q;
	logic signed [POS_W-1:0]  out_x_q, out_y_q;
	logic [ANG_W-1:0]         out_head_q;
	logic signed [QUAT_W-1:0] out_qz_q, out_qw_q;
	logic signed [VEL_W-1:0]  out_vx_q, out_vy_q, out_rate_q;

	// cordic
	logic signed [CS_W-1:0] cx_q, cy_q;
	logic signed [CZ_W-1:0] cz_q;
	logic                   cflip_q;
	logic [STEP_W-1:0]      cstep_q;
	logic                   cor_load, cor_run, cor_last;
	logic [ANG_W-1:0]       cor_angle, cor_sum, cor_fold;
	logic signed [CS_W-1:0] dx, dy, cos_v, sin_v;
	logic signed [CZ_W-1:0] atan_v;

	// serial units
	logic                    mac_start_q, div_start_q;
	logic                    mac_go, div_go;
	mac_ctl_t                mac0_ctl, mac1_ctl;
	div_ctl_t                div0_ctl, div1_ctl;
	logic signed [ACC_W-1:0] mac0_mcand, mac1_mcand, acc0, acc1;
	logic [MB_W-1:0]         mac0_mplier, mac1_mplier;
	logic                    mac0_done, mac1_done;
	logic [DVD_W-1:0]        div0_dvd, div0_dsr, div1_dvd;
	logic [DQ_W-1:0]         quo0, quo1;
	logic                    div0_done, div1_done;

	// datapath glue
	logic signed [WX_W-1:0]  wx_v, wy_v;
	logic signed [ACC_W-1:0] abs0, abs1;
	logic signed [QH_W-1:0]  qh_v, qh_abs;
	logic                    neg0, neg1;
	logic signed [SUM_W-1:0] step_x, step_y, sum_x, sum_y;
	logic [DQ_W-1:0]         head_step;
	logic [ANG_W-1:0]        yaw_nxt;
	logic                    cmd_fire, emit_fire;

	function automatic logic [POS_W-1:0] sat_pos(input logic signed [SUM_W-1:0] v);
		logic same;
		same = (&v[SUM_W-1:POS_W-1]) || !(|v[SUM_W-1:POS_W-1]);
		if (same) begin
			return v[POS_W-1:0];
		end
		return v[SUM_W-1] ? {1'b1, {(POS_W-1){1'b0}}} : {1'b0, {(POS_W-1){1'b1}}};
	endfunction

	// q2.30 to q1.15, round half up, saturate
	function automatic logic [QUAT_W-1:0] to_q15(input logic signed [CS_W-1:0] v);
		logic signed [QS_W-1:0] s;
		logic [QS_W-16:0]       r;
		s = QS_W'(v) + QS_W'(16384);
		r = s[QS_W-1:15];
		if ((&r[QS_W-16:QUAT_W-1]) || !(|r[QS_W-16:QUAT_W-1])) begin
			return r[QUAT_W-1:0];
		end
		return r[QS_W-16] ? {1'b1, {(QUAT_W-1){1'b0}}} : {1'b0, {(QUAT_W-1){1'b1}}};
	endfunction

	assign cmd_fire  = (state_q == S_IDLE) && cmd_valid;
	assign emit_fire = (state_q == S_EMIT) && (!pose_valid_q || !pose_stall);
	assign cmd_stall = (state_q != S_IDLE);

	// ---------------- cordic: one rotation per cycle ----------------
	assign cor_run   = (state_q == S_COR1) || (state_q == S_COR2);
	assign cor_last  = cor_run && (cstep_q == STEP_W'(CORDIC_STEPS - 1));
	assign cor_load  = (cmd_fire && kind == KIND_TICK) ||
		(state_q == S_DIV_H && div0_done);
	// second pass works on half the new heading
	assign cor_angle = (state_q == S_IDLE) ? yaw_q : {1'b0, yaw_nxt[ANG_W-1:1]};
	// fold into [-pi/2, pi/2) by half a turn, negate results afterwards
	assign cor_sum   = cor_angle + QUARTER_TURN;
	assign cor_fold  = cor_sum[ANG_W-1] ? cor_angle + HALF_TURN : cor_angle;
	assign dx        = cy_q >>> cstep_q;
	assign dy        = cx_q >>> cstep_q;
	assign atan_v    = signed'({1'b0, cordic_atan(ATAN_IDX_W'(cstep_q))});
	assign cos_v     = cflip_q ? -cx_q : cx_q;
	assign sin_v     = cflip_q ? -cy_q : cy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cstep_q <= '0;
		end else if (cor_load) begin
			cstep_q <= '0;
		end else if (cor_run && !cor_last) begin
			cstep_q <= cstep_q + STEP_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cor_load) begin
			cx_q    <= CS_W'(CORDIC_GAIN);
			cy_q    <= '0;
			cz_q    <= CZ_W'(signed'(cor_fold));
			cflip_q <= cor_sum[ANG_W-1];
		end else if (cor_run) begin
			if (!cz_q[CZ_W-1]) begin
				cx_q <= cx_q - dx;
				cy_q <= cy_q + dy;
				cz_q <= cz_q - atan_v;
			end else begin
				cx_q <= cx_q + dx;
				cy_q <= cy_q - dy;
				cz_q <= cz_q + atan_v;
			end
		end
	end

	// ---------------- multiply-accumulate operand selection ----------------
	assign wx_v = acc0[WX_W+PROD_SHIFT-1:PROD_SHIFT];
	assign wy_v = acc1[WX_W+PROD_SHIFT-1:PROD_SHIFT];

	always_comb begin
		mac0_ctl    = '{start: mac_start_q, clear: 1'b1, neg: 1'b0,
			nbits: MAC_CNT_W'(VEL_W)};
		mac1_ctl    = '{start: 1'b0, clear: 1'b1, neg: 1'b0,
			nbits: MAC_CNT_W'(VEL_W)};
		mac0_mcand  = '0;
		mac0_mplier = '0;
		mac1_mcand  = '0;
		mac1_mplier = '0;
		case (state_q)
			// vf*cos and vf*sin
			S_MUL_A: begin
				mac1_ctl.start = mac_start_q;
				mac0_mcand     = ACC_W'(cos_v);
				mac0_mplier    = MB_W'(cmd_fwd_q);
				mac1_mcand     = ACC_W'(sin_v);
				mac1_mplier    = MB_W'(cmd_fwd_q);
			end
			// minus vl*sin, plus vl*cos
			S_MUL_B: begin
				mac1_ctl.start = mac_start_q;
				mac0_ctl.clear = 1'b0;
				mac1_ctl.clear = 1'b0;
				mac0_ctl.neg   = 1'b1;
				mac0_mcand     = ACC_W'(sin_v);
				mac0_mplier    = MB_W'(cmd_lat_q);
				mac1_mcand     = ACC_W'(cos_v);
				mac1_mplier    = MB_W'(cmd_lat_q);
			end
			// world velocity times elapsed time
			S_MUL_C: begin
				mac1_ctl.start = mac_start_q;
				mac0_ctl.nbits = MAC_CNT_W'(DT_W + 1);
				mac1_ctl.nbits = MAC_CNT_W'(DT_W + 1);
				mac0_mcand     = ACC_W'(wx_v);
				mac0_mplier    = MB_W'(dt_q);
				mac1_mcand     = ACC_W'(wy_v);
				mac1_mplier    = MB_W'(dt_q);
			end
			S_MUL_T: begin
				mac0_ctl.nbits = MAC_CNT_W'(DT_W + 1);
				mac0_mcand     = ACC_W'(cmd_turn_q);
				mac0_mplier    = MB_W'(dt_q);
			end
			// rate*time into binary-angle units, q.16
			S_MUL_K: begin
				mac0_ctl.nbits = MAC_CNT_W'(MB_W);
				mac0_mcand     = acc0;
				mac0_mplier    = ANGLE_SCALE;
			end
			default: begin
				mac0_ctl.start = 1'b0;
			end
		endcase
	end

	poi_mac u_mac0 (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (mac0_ctl),
		.mcand  (mac0_mcand),
		.mplier (mac0_mplier),
		.acc    (acc0),
		.done   (mac0_done)
	);

	poi_mac u_mac1 (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (mac1_ctl),
		.mcand  (mac1_mcand),
		.mplier (mac1_mplier),
		.acc    (acc1),
		.done   (mac1_done)
	);

	// ---------------- rounded divides, sign handled outside ----------------
	assign neg0   = acc0[ACC_W-1];
	assign neg1   = acc1[ACC_W-1];
	assign abs0   = neg0 ? -acc0 : acc0;
	assign abs1   = neg1 ? -acc1 : acc1;
	// floor shift first, magnitude after
	assign qh_v   = acc0[ACC_W-1:ANGLE_FRAC];
	assign qh_abs = neg0 ? -qh_v : qh_v;

	always_comb begin
		if (state_q == S_DIV_H) begin
			div0_dvd       = qh_abs[DVD_W-1:0] + HEAD_HALF;
			div0_dsr       = HEAD_DSR;
			div0_ctl.nbits = DIV_CNT_W'(HEAD_QB);
		end else begin
			div0_dvd       = abs0[DVD_W-1:0] + POS_HALF;
			div0_dsr       = POS_DSR;
			div0_ctl.nbits = DIV_CNT_W'(QB_POS);
		end
		div0_ctl.start = div_start_q;
		div1_ctl.start = div_start_q && (state_q == S_DIV_P);
		div1_ctl.nbits = DIV_CNT_W'(QB_POS);
		div1_dvd       = abs1[DVD_W-1:0] + POS_HALF;
	end

	poi_div u_div0 (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (div0_ctl),
		.dividend (div0_dvd),
		.divisor  (div0_dsr),
		.quotient (quo0),
		.done     (div0_done)
	);

	poi_div u_div1 (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (div1_ctl),
		.dividend (div1_dvd),
		.divisor  (POS_DSR),
		.quotient (quo1),
		.done     (div1_done)
	);

	// ---------------- pose update ----------------
	assign step_x    = neg0 ? -SUM_W'(quo0) : SUM_W'(quo0);
	assign step_y    = neg1 ? -SUM_W'(quo1) : SUM_W'(quo1);
	assign sum_x     = SUM_W'(world_x_q) + step_x;
	assign sum_y     = SUM_W'(world_y_q) + step_y;
	assign head_step = neg0 ? -quo0 : quo0;
	// heading wraps modulo a full turn
	assign yaw_nxt   = yaw_q + head_step[ANG_W-1:0];

	// ---------------- sequencer ----------------
	// start pulses for the serial units, registered so that each arrives as the next step begins
	assign mac_go = (state_q == S_COR1 && cor_last) ||
		((state_q == S_MUL_A || state_q == S_MUL_B || state_q == S_MUL_T) && mac0_done) ||
		(state_q == S_DIV_P && div0_done);
	assign div_go = (state_q == S_MUL_C || state_q == S_MUL_K) && mac0_done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			mac_start_q  <= 1'b0;
			div_start_q  <= 1'b0;
			pose_valid_q <= 1'b0;
			cmd_fwd_q    <= '0;
			cmd_lat_q    <= '0;
			cmd_turn_q   <= '0;
			world_x_q    <= '0;
			world_y_q    <= '0;
			yaw_q        <= '0;
			dt_q         <= '0;
		end else begin
			mac_start_q <= mac_go;
			div_start_q <= div_go;
			if (emit_fire) begin
				pose_valid_q <= 1'b1;
			end else if (pose_valid_q && !pose_stall) begin
				pose_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (cmd_valid) begin
						if (kind == KIND_TICK) begin
							dt_q    <= elapsed_us;
							state_q <= S_COR1;
						end else begin
							cmd_fwd_q  <= forward_velocity;
							cmd_lat_q  <= lateral_velocity;
							cmd_turn_q <= turn_rate;
						end
					end
				end
				S_COR1: begin
					if (cor_last) begin
						state_q <= S_MUL_A;
					end
				end
				S_MUL_A: begin
					if (mac0_done) begin
						state_q <= S_MUL_B;
					end
				end
				S_MUL_B: begin
					if (mac0_done) begin
						state_q <= S_MUL_C;
					end
				end
				S_MUL_C: begin
					if (mac0_done) begin
						state_q <= S_DIV_P;
					end
				end
				S_DIV_P: begin
					if (div0_done) begin
						world_x_q <= sat_pos(sum_x);
						world_y_q <= sat_pos(sum_y);
						state_q   <= S_MUL_T;
					end
				end
				S_MUL_T: begin
					if (mac0_done) begin
						state_q <= S_MUL_K;
					end
				end
				S_MUL_K: begin
					if (mac0_done) begin
						state_q <= S_DIV_H;
					end
				end
				S_DIV_H: begin
					if (div0_done) begin
						yaw_q   <= yaw_nxt;
						state_q <= S_COR2;
					end
				end
				S_COR2: begin
					if (cor_last) begin
						state_q <= S_EMIT;
					end
				end
				S_EMIT: begin
					if (emit_fire) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// pose beat payload, loaded when the output slot is free
	always_ff @(posedge clk) begin
		if (emit_fire) begin
			out_x_q    <= world_x_q;
			out_y_q    <= world_y_q;
			out_head_q <= yaw_q;
			out_qz_q   <= to_q15(sin_v);
			out_qw_q   <= to_q15(cos_v);
			out_vx_q   <= cmd_fwd_q;
			out_vy_q   <= cmd_lat_q;
			out_rate_q <= cmd_turn_q;
		end
	end

	assign pose_valid = pose_valid_q;
	assign pos_x      = out_x_q;
	assign pos_y      = out_y_q;
	assign heading    = out_head_q;
	assign quat_z     = out_qz_q;
	assign quat_w     = out_qw_q;
	assign vel_x_echo = out_vx_q;
	assign vel_y_echo = out_vy_q;
	assign rate_echo  = out_rate_q;

	// ---------------- checks ----------------
	a_mac_done_in_mul: assert property (@(posedge clk) disable iff (!arst_n)
		mac0_done |-> (state_q == S_MUL_A || state_q == S_MUL_B ||
		state_q == S_MUL_C || state_q == S_MUL_T || state_q == S_MUL_K))
		else $error("multiplier finished outside a multiply step");

	a_mac_pair: assert property (@(posedge clk) disable iff (!arst_n)
		mac1_done |-> mac0_done)
		else $error("multiplier lanes out of step");

	a_div_pair: assert property (@(posedge clk) disable iff (!arst_n)
		div1_done |-> div0_done)
		else $error("divider lanes out of step");

	a_pose_from_emit: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(pose_valid_q) |-> $past(state_q) == S_EMIT)
		else $error("pose beat raised outside emit");

	a_yaw_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_DIV_H) |=> $stable(yaw_q))
		else $error("heading changed outside heading update");

endmodule
